// File: design/sal_pkg.sv
package sal_pkg;
    localparam int FRAC_BITS_DEF = 16;
    localparam logic [2:0] REG_LIN_LIMIT  = 3'd0;
    localparam logic [2:0] REG_ANG_LIMIT  = 3'd1;
    localparam logic [2:0] REG_LIN_ACCEL  = 3'd2;
    localparam logic [2:0] REG_ANG_ACCEL  = 3'd3;
    localparam logic [2:0] REG_CENT_LIMIT = 3'd4;
    localparam logic [2:0] REG_PERIOD     = 3'd5;
    localparam logic [2:0] REG_CURVE_MODE = 3'd6;

    typedef struct packed {
        logic signed [31:0] req_linear;
        logic signed [31:0] req_angular;
        logic signed [31:0] curvature;
    } t_in;

    typedef struct packed {
        logic signed [31:0] lim_linear;
        logic signed [31:0] lim_angular;
    } t_out;

    typedef struct packed {
        logic [2:0]  index;
        logic [31:0] data;
    } t_cfg;
endpackage

// File: design/speed_accel_limiter.sv
// sequence: step products, slew windows, then the output register; in curve mode
// with nonzero curvature two divides and a root come before the clamp and the angular
// product (the root loop does no iterations when the bound saturates)
// no input while busy or while a result waits, so a new beat is taken only after
// the previous result has been accepted
// reset: synchronous active low, registers to defaults, state to zero
module speed_accel_limiter (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  sal_pkg::t_in   i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output sal_pkg::t_out  o_data,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  sal_pkg::t_cfg  i_cfg
);
    import sal_pkg::*;

    localparam int FRAC_BITS = FRAC_BITS_DEF;

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_STEPL = 4'd1;  // linear step product
    localparam logic [3:0] S_STEPA = 4'd2;  // angular step product
    localparam logic [3:0] S_SLEWL = 4'd3;
    localparam logic [3:0] S_SLEWA = 4'd4;
    localparam logic [3:0] S_DIVA  = 4'd5;  // angular bound divide
    localparam logic [3:0] S_DIVC  = 4'd6;  // centripetal divide
    localparam logic [3:0] S_SQRT  = 4'd7;
    localparam logic [3:0] S_CLAMP = 4'd8;
    localparam logic [3:0] S_PROD  = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    localparam logic [63:0] SAT31 = 64'h7FFF_FFFF;

    // configuration
    logic [30:0] r_lin_lim, r_ang_lim, r_lin_acc, r_ang_acc, r_cent_lim;
    logic [16:0] r_period;
    logic        r_curve;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lin_lim  <= 31'd65536;
            r_ang_lim  <= 31'd65536;
            r_lin_acc  <= 31'd65536;
            r_ang_acc  <= 31'd65536;
            r_cent_lim <= 31'd65536;
            r_period   <= 17'd655;
            r_curve    <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg.index)
                REG_LIN_LIMIT:  r_lin_lim  <= i_cfg.data[30:0];
                REG_ANG_LIMIT:  r_ang_lim  <= i_cfg.data[30:0];
                REG_LIN_ACCEL:  r_lin_acc  <= i_cfg.data[30:0];
                REG_ANG_ACCEL:  r_ang_acc  <= i_cfg.data[30:0];
                REG_CENT_LIMIT: r_cent_lim <= i_cfg.data[30:0];
                REG_PERIOD:     r_period   <= i_cfg.data[16:0];
                REG_CURVE_MODE: r_curve    <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    logic [3:0]         r_state, n_state;
    t_in                r_in;
    logic signed [33:0] r_lin, r_ang;     // working values
    logic [47:0]        r_prod;            // shared multiplier output
    logic [32:0]        r_abound;
    logic [63:0]        r_x, r_res, r_bit;  // square root working set
    logic [32:0]        r_cbound;
    logic signed [31:0] r_prev_lin, r_prev_ang;
    logic [5:0]         r_cnt;
    logic               r_div_start;
    t_out               r_out;
    logic               r_ovalid;

    // shared multiplier
    logic [31:0] w_ma, w_mb;
    logic [63:0] w_mul;
    assign w_mul = {32'd0, w_ma} * {32'd0, w_mb};

    logic [31:0] w_ak;
    assign w_ak = r_in.curvature[31] ? 32'(-r_in.curvature) : r_in.curvature;

    logic [32:0] w_mag;
    assign w_mag = r_lin[33] ? 33'(-r_lin) : 33'(r_lin);

    always_comb begin
        w_ma = 32'd0;
        w_mb = 32'd0;
        unique case (r_state)
            S_STEPL: begin w_ma = {1'b0, r_lin_acc}; w_mb = {15'd0, r_period}; end
            S_STEPA: begin w_ma = {1'b0, r_ang_acc}; w_mb = {15'd0, r_period}; end
            S_PROD:  begin w_ma = w_ak; w_mb = w_mag[31:0]; end
            default: ;
        endcase
    end

    // divider shared by both curvature bounds
    logic [63:0] w_div_num, w_quot;
    logic        w_div_done;
    assign w_div_num = (r_state == S_DIVC)
        ? (64'(r_cent_lim) << FRAC_BITS) : (64'(r_ang_lim) << FRAC_BITS);

    sal_divider u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_div_start),
        .i_num  (w_div_num),
        .i_den  (w_ak),
        .o_done (w_div_done),
        .o_quot (w_quot)
    );

    // slew window and speed clamp, one channel per cycle
    function automatic logic signed [33:0] slew(input logic signed [33:0] req,
        input logic signed [31:0] prev, input logic [47:0] prod, input logic [30:0] lim);
        logic signed [33:0] stp, lo, hi, v;
        stp = $signed({1'b0, 33'(prod >> FRAC_BITS)});
        lo  = 34'(prev) - stp;
        hi  = 34'(prev) + stp;
        v   = (req < lo) ? lo : ((req > hi) ? hi : req);
        if (v < -$signed({3'd0, lim})) v = -$signed({3'd0, lim});
        if (v > $signed({3'd0, lim})) v = $signed({3'd0, lim});
        return v;
    endfunction

    logic [63:0] w_sq_t;
    assign w_sq_t = r_res + r_bit;

    logic [32:0] w_mn;
    assign w_mn = (r_abound < r_cbound) ? r_abound : r_cbound;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_valid && !r_ovalid) n_state = S_STEPL;
            S_STEPL: n_state = S_STEPA;
            S_STEPA: n_state = S_SLEWL;
            S_SLEWL: n_state = S_SLEWA;
            S_SLEWA: n_state = (r_curve && r_in.curvature != 0) ? S_DIVA : S_OUT;
            S_DIVA:  if (w_div_done) n_state = S_DIVC;
            S_DIVC:  if (w_div_done) n_state = S_SQRT;
            S_SQRT:  if (r_bit == 64'd0) n_state = S_CLAMP;
            S_CLAMP: n_state = S_PROD;
            S_PROD:  n_state = S_OUT;
            S_OUT:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_prev_lin  <= '0;
            r_prev_ang  <= '0;
            r_ovalid    <= 1'b0;
            r_div_start <= 1'b0;
        end else begin
            r_state     <= n_state;
            // start pulse for the angular divide, then for the centripetal one
            r_div_start <= ((r_state == S_SLEWA) && r_curve && (r_in.curvature != 0))
                        || ((r_state == S_DIVA) && w_div_done);
            r_ovalid    <= (r_state == S_OUT) || (r_ovalid && !i_ready);
            unique case (r_state)
                S_IDLE: if (i_valid && !r_ovalid) r_in <= i_data;
                S_STEPL: r_prod <= w_mul[47:0];
                S_STEPA: begin
                    r_lin  <= slew(34'(r_in.req_linear), r_prev_lin, r_prod, r_lin_lim);
                    r_prod <= w_mul[47:0];
                end
                S_SLEWL: r_ang <= slew(34'(r_in.req_angular), r_prev_ang, r_prod, r_ang_lim);
                S_DIVA: if (w_div_done) begin
                    r_abound    <= (w_quot > SAT31) ? 33'(SAT31) : w_quot[32:0];
                end
                S_DIVC: if (w_div_done) begin
                    r_cnt <= 6'd0;
                    if (w_quot >= (64'd1 << (62 - FRAC_BITS))) begin
                        r_cbound <= 33'(SAT31);
                        r_bit    <= 64'd0;
                    end else begin
                        r_x      <= w_quot << FRAC_BITS;
                        r_res    <= 64'd0;
                        r_bit    <= 64'd1 << 62;
                    end
                end
                S_SQRT: begin
                    if (r_bit != 64'd0) begin
                        if (r_res == 64'd0 && r_bit > r_x) begin
                            r_bit <= r_bit >> 2;
                        end else if (r_x >= w_sq_t) begin
                            r_x   <= r_x - w_sq_t;
                            r_res <= (r_res >> 1) + r_bit;
                            r_bit <= r_bit >> 2;
                        end else begin
                            r_res <= r_res >> 1;
                            r_bit <= r_bit >> 2;
                        end
                    end else if (r_cbound != 33'(SAT31) || r_cnt != 6'd0) begin
                        r_cbound <= (r_res > SAT31) ? 33'(SAT31) : r_res[32:0];
                    end
                    r_cnt <= 6'd1;
                end
                S_CLAMP: begin
                    if (r_lin > $signed({1'b0, w_mn})) r_lin <= $signed({1'b0, w_mn});
                    else if (r_lin < -$signed({1'b0, w_mn})) r_lin <= -$signed({1'b0, w_mn});
                end
                S_PROD: begin
                    if (r_in.curvature[31])
                        r_ang <= ((w_mul >> FRAC_BITS) > 64'h8000_0000)
                            ? -34'sh8000_0000 : -$signed({1'b0, 33'(w_mul >> FRAC_BITS)});
                    else
                        r_ang <= ((w_mul >> FRAC_BITS) > SAT31)
                            ? 34'sh7FFF_FFFF : $signed({1'b0, 33'(w_mul >> FRAC_BITS)});
                end
                S_OUT: begin
                    r_prev_lin       <= r_lin[31:0];
                    r_prev_ang       <= r_ang[31:0];
                    r_out.lim_linear <= r_lin[31:0];
                    r_out.lim_angular <= r_ang[31:0];
                end
                default: ;
            endcase
        end
    end

    assign o_ready = (r_state == S_IDLE) && !r_ovalid;
    assign o_valid = r_ovalid;
    assign o_data  = r_out;

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_ready) else $error("ready while busy");
    a_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |=> o_valid) else $error("result lost");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> $stable(o_data)) else $error("result changed");
endmodule

// File: design/sal_divider.sv
module sal_divider (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [63:0] o_quot
);
    // restoring divide, one quotient bit per cycle
    logic [63:0] r_quot, n_quot;
    logic [31:0] r_rem, n_rem;
    logic [6:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic [32:0] w_trial;

    assign w_trial = {r_rem, r_quot[63]};

    always_comb begin
        n_quot = r_quot;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        if (i_start) begin
            n_quot = i_num;
            n_rem  = '0;
            n_cnt  = 7'd64;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_trial >= {1'b0, i_den}) begin
                n_rem  = 32'(w_trial - {1'b0, i_den});
                n_quot = {r_quot[62:0], 1'b1};
            end else begin
                n_rem  = w_trial[31:0];
                n_quot = {r_quot[62:0], 1'b0};
            end
            n_cnt = r_cnt - 7'd1;
            if (r_cnt == 7'd1) n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_quot <= n_quot;
        r_rem  <= n_rem;
    end

    assign o_done = r_busy && (r_cnt == 7'd1);
    assign o_quot = n_quot;
endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import sal_pkg::*;

    localparam int FB = 16;
    localparam int N_RANDOM = 1830;
    localparam longint CYCLE_LIMIT = 10_000_000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    t_in  i_data = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    t_out o_data;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    t_cfg i_cfg = '0;

    speed_accel_limiter dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_data(i_data),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg(i_cfg)
    );

    always #2 i_clk = ~i_clk;

    // predictor copy of registers and state
    longint lin_lim, ang_lim, lin_acc, ang_acc, cent_lim, period, curve_on;
    longint last_lin, last_ang;

    t_in  pending_beats[$];
    t_out limited_q[$];
    int   errors = 0;
    int   mismatches = 0;
    int   results_seen = 0;
    int   curve_items = 0;
    longint cycles = 0;
    logic in_fire = 1'b0;
    logic hold_sender = 1'b0;
    int   send_gap = 0;
    int   recv_gap = 0;

    function automatic int rand_gap();
        int r;
        r = $urandom_range(99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(3);
        if (r < 98) return $urandom_range(20);
        return $urandom_range(250);
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic longint root_floor(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint slew_limit(longint req, longint prv, longint acc, longint lim);
        longint st;
        st = (acc * period) >>> FB;
        return clip(clip(req, prv - st, prv + st), -lim, lim);
    endfunction

    // compute the limited pair for one input beat and advance state
    function automatic t_out limit_beat(t_in b);
        longint lin, ang, k, ak, abnd, q, cbnd, mag, prod;
        t_out o;
        k = longint'(b.curvature);
        lin = slew_limit(longint'(b.req_linear), last_lin, lin_acc, lin_lim);
        ang = slew_limit(longint'(b.req_angular), last_ang, ang_acc, ang_lim);
        if (curve_on != 0 && k != 0) begin
            ak = (k < 0) ? -k : k;
            abnd = (ang_lim << FB) / ak;
            q = (cent_lim << FB) / ak;
            if (abnd > 64'h7FFFFFFF) abnd = 64'h7FFFFFFF;
            lin = clip(lin, -abnd, abnd);
            if (q >= (64'd1 << (62 - FB))) cbnd = 64'h7FFFFFFF;
            else cbnd = root_floor(q << FB);
            if (cbnd > 64'h7FFFFFFF) cbnd = 64'h7FFFFFFF;
            lin = clip(lin, -cbnd, cbnd);
            mag = (lin < 0) ? -lin : lin;
            prod = (ak * mag) >>> FB;
            if (k < 0) ang = -((prod > 64'h80000000) ? 64'h80000000 : prod);
            else ang = (prod > 64'h7FFFFFFF) ? 64'h7FFFFFFF : prod;
        end
        last_lin = lin;
        last_ang = ang;
        o.lim_linear = lin[31:0];
        o.lim_angular = ang[31:0];
        return o;
    endfunction

    function automatic void note_register(logic [2:0] idx, logic [31:0] d);
        case (idx)
            REG_LIN_LIMIT:  lin_lim  = d[30:0];
            REG_ANG_LIMIT:  ang_lim  = d[30:0];
            REG_LIN_ACCEL:  lin_acc  = d[30:0];
            REG_ANG_ACCEL:  ang_acc  = d[30:0];
            REG_CENT_LIMIT: cent_lim = d[30:0];
            REG_PERIOD:     period   = d[16:0];
            REG_CURVE_MODE: curve_on = d[0];
            default: ;
        endcase
    endfunction

    // driver: one beat per handshake, gaps drawn at random
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (in_fire) begin
                // beat taken at last rising edge
                if (pending_beats.size() > 0) begin
                    void'(pending_beats.pop_front());
                end
                send_gap = rand_gap();
            end
            if (!i_valid || in_fire) begin
                if (send_gap > 0 || hold_sender || pending_beats.size() == 0) begin
                    if (send_gap > 0) send_gap--;
                    i_valid <= 1'b0;
                end else begin
                    i_valid <= 1'b1;
                    i_data <= pending_beats[0];
                end
            end
            if (recv_gap > 0) begin
                recv_gap--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                recv_gap = ($urandom_range(3) == 0) ? rand_gap() : 0;
            end
        end
    end

    // monitor: predict on input beats, compare on output beats
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            cycles++;
            in_fire = i_valid && o_ready;
            if (i_valid && o_ready) begin
                limited_q.push_back(limit_beat(i_data));
                if (curve_on != 0 && i_data.curvature != 0) curve_items++;
            end
            if (o_valid && i_ready) begin
                results_seen++;
                if (limited_q.size() == 0) begin
                    errors++;
                    $display("unexpected result beat lin=%0d ang=%0d",
                             o_data.lim_linear, o_data.lim_angular);
                end else begin
                    t_out e;
                    e = limited_q.pop_front();
                    if (e !== o_data) begin
                        errors++;
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch lin exp %0d got %0d, ang exp %0d got %0d",
                                     e.lim_linear, o_data.lim_linear,
                                     e.lim_angular, o_data.lim_angular);
                    end
                end
            end
            if (cycles > CYCLE_LIMIT) begin
                $display("[speed_accel_limiter] ERROR");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] d);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg.index <= idx;
        i_cfg.data <= d;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        note_register(idx, d);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // wait for every expectation, then let the block settle
    task automatic drain();
        while (pending_beats.size() > 0 || i_valid || limited_q.size() > 0)
            @(posedge i_clk);
        repeat (250) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_limit();
        case ($urandom_range(5))
            0: return 32'd0;
            1: return 32'h7FFFFFFF;
            2: return $urandom_range(32'h40000);
            3: return $urandom;
            default: return $urandom_range(32'h400000);
        endcase
    endfunction

    function automatic logic [31:0] rand_speed();
        case ($urandom_range(7))
            0: return 32'h80000000;
            1: return 32'h7FFFFFFF;
            2: return 32'd0;
            3: return $urandom;
            default: return $signed($urandom_range(32'h60000)) - 32'sh30000;
        endcase
    endfunction

    function automatic logic [31:0] rand_curv();
        case ($urandom_range(7))
            0: return 32'h80000000;
            1: return 32'd0;
            2: return 32'h7FFFFFFF;
            3: return $urandom;
            4: return ($urandom_range(1) ? 32'd1 : 32'hFFFFFFFF);
            default: return $signed($urandom_range(32'h40000)) - 32'sh20000;
        endcase
    endfunction

    function automatic t_in mk(logic [31:0] l, logic [31:0] a, logic [31:0] c);
        t_in b;
        b.req_linear = l;
        b.req_angular = a;
        b.curvature = c;
        return b;
    endfunction

    initial begin
        lin_lim = 65536; ang_lim = 65536; lin_acc = 65536; ang_acc = 65536;
        cent_lim = 65536; period = 655; curve_on = 0;
        last_lin = 0; last_ang = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset settings, then full-scale curve mode
        pending_beats.push_back(mk(32'h7FFFFFFF, 32'h80000000, 32'd0));
        pending_beats.push_back(mk(32'h80000000, 32'h7FFFFFFF, 32'h10000));
        pending_beats.push_back(mk(32'd0, 32'd0, 32'd0));
        drain();
        write_reg(REG_LIN_LIMIT, 32'hFFFFFFFF);
        write_reg(REG_ANG_LIMIT, 32'h7FFFFFFF);
        write_reg(REG_LIN_ACCEL, 32'h7FFFFFFF);
        write_reg(REG_ANG_ACCEL, 32'h7FFFFFFF);
        write_reg(REG_CENT_LIMIT, 32'h7FFFFFFF);
        write_reg(REG_PERIOD, 32'h10000);
        write_reg(REG_CURVE_MODE, 32'd1);
        write_reg(3'd7, 32'h12345678);  // out-of-range index is ignored
        pending_beats.push_back(mk(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000));
        pending_beats.push_back(mk(32'h80000000, 32'h80000000, 32'h7FFFFFFF));
        pending_beats.push_back(mk(32'h7FFFFFFF, 32'd0, 32'd1));
        pending_beats.push_back(mk(32'h80000000, 32'd0, 32'hFFFFFFFF));
        pending_beats.push_back(mk(32'h00020000, 32'd5, 32'h00008000));
        pending_beats.push_back(mk(32'h12345678, 32'd5, 32'd0));
        drain();
        // zero limits and zero period collapse everything
        write_reg(REG_PERIOD, 32'd0);
        pending_beats.push_back(mk(32'h7FFFFFFF, 32'h80000000, 32'h10000));
        drain();
        write_reg(REG_PERIOD, 32'h1FFFF);
        write_reg(REG_LIN_LIMIT, 32'd0);
        write_reg(REG_ANG_LIMIT, 32'd0);
        write_reg(REG_CENT_LIMIT, 32'd0);
        pending_beats.push_back(mk(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h10000));
        pending_beats.push_back(mk(32'h80000000, 32'h80000000, 32'h80000000));
        drain();
        write_reg(REG_LIN_ACCEL, 32'd0);
        write_reg(REG_ANG_ACCEL, 32'd0);
        write_reg(REG_CURVE_MODE, 32'd0);
        pending_beats.push_back(mk(32'h7FFFFFFF, 32'h7FFFFFFF, 32'd3));
        drain();

        // random phases with fresh settings each time
        for (int ph = 0; ph < 12; ph++) begin
            write_reg(REG_LIN_LIMIT, rand_limit());
            write_reg(REG_ANG_LIMIT, rand_limit());
            write_reg(REG_LIN_ACCEL, rand_limit());
            write_reg(REG_ANG_ACCEL, rand_limit());
            write_reg(REG_CENT_LIMIT, rand_limit());
            write_reg(REG_PERIOD, ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h10000));
            write_reg(REG_CURVE_MODE, (ph % 3 == 2) ? 32'd0 : $urandom);
            for (int n = 0; n < N_RANDOM / 12; n++) begin
                pending_beats.push_back(mk(rand_speed(), rand_speed(), rand_curv()));
                if (ph == 4 && n == 40) begin
                    // sender holds off until the pipe has fully drained
                    while (pending_beats.size() > 1) @(posedge i_clk);
                    hold_sender = 1'b1;
                    while (pending_beats.size() > 1 || i_valid || limited_q.size() > 0)
                        @(posedge i_clk);
                    hold_sender = 1'b0;
                end
            end
            drain();
        end

        $display("covered %0d result beats, %0d under curvature constraints",
                 results_seen, curve_items);
        if (errors == 0) begin
            $display("[speed_accel_limiter] OK");
        end else begin
            $display("%0d errors, %0d mismatches", errors, mismatches);
            $display("[speed_accel_limiter] ERROR");
        end
        $finish;
    end
endmodule

// File: speed_accel_limiter.f
design/sal_pkg.sv
design/sal_divider.sv
design/speed_accel_limiter.sv
dv/testbench.sv
